>>> src/isc_pkg.sv
// Shared types and constants for the insertion sort engine.
// Depends on nothing; every other file refers to it by scoped names.
package isc_pkg;

    // Number of cells in the chain, which is the largest run that is kept.
    localparam int unsigned DEPTH = 16;
    localparam int unsigned VALUE_W = 32;

    // One input transfer.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in_item;

    // One result transfer.
    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      run_end;
        logic                      overflow;
    } t_out_item;

    // Per-cycle command that the control broadcasts to every cell.
    typedef struct packed {
        logic insert;   // place the broadcast value into the list
        logic shift;    // every cell takes its right neighbor's entry
    } t_cell_ctrl;

endpackage

>>> src/isc_cell.sv
// One cell of the insertion chain: a valid bit and one list entry.
// Depends on isc_pkg.
module isc_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  isc_pkg::t_cell_ctrl                  i_ctrl,
    input  logic signed [isc_pkg::VALUE_W-1:0]   i_ins_value,
    input  logic                                 i_left_valid,
    input  logic                                 i_left_gt,
    input  logic signed [isc_pkg::VALUE_W-1:0]   i_left_value,
    input  logic                                 i_right_valid,
    input  logic signed [isc_pkg::VALUE_W-1:0]   i_right_value,
    output logic                                 o_valid,
    output logic                                 o_gt,
    output logic signed [isc_pkg::VALUE_W-1:0]   o_value
);

    logic                               r_valid;
    logic                               n_valid;
    logic signed [isc_pkg::VALUE_W-1:0] r_value;
    logic signed [isc_pkg::VALUE_W-1:0] n_value;
    logic                               gt;

    // Strictly greater, so an equal value lands above its equals.
    assign gt = r_valid && (r_value > i_ins_value);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.shift) begin
            n_valid = i_right_valid;
            n_value = i_right_value;
        end else if (i_ctrl.insert) begin
            if (gt || (!r_valid && i_left_valid)) begin
                n_valid = 1'b1;
                if (i_left_gt) begin
                    n_value = i_left_value;
                end else begin
                    n_value = i_ins_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_valid = r_valid;
    assign o_gt    = gt;
    assign o_value = r_value;

endmodule

>>> src/insertion_sort_engine.sv
// Top level of the insertion sort engine: the cell chain and its control.
// Depends on isc_pkg and isc_cell.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+----------------------------
//  input   | in        | i_in_valid / o_in_ready   | i_in_data  (isc_pkg::t_in_item)
//  output  | out       | o_out_valid / i_out_ready | o_out_data (isc_pkg::t_out_item)
//
// While a run is being collected, one input transfer is taken every cycle; the
// broadcast compare in all cells at once sets that figure.
// A transfer marked last closes the run: the next cycle starts draining the
// chain through cell 0, one result per cycle while the output side takes them,
// and new input is taken again once the last kept entry has left cell 0.
// Output stalls simply pause the drain; input is not taken while draining.
// Reset (synchronous, active low) empties the chain and the output register.
module insertion_sort_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  isc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output isc_pkg::t_out_item o_out_data
);

    localparam int unsigned D = isc_pkg::DEPTH;

    // Chain taps, one per cell.
    logic                               c_valid [D];
    logic                               c_gt    [D];
    logic signed [isc_pkg::VALUE_W-1:0] c_value [D];

    isc_pkg::t_cell_ctrl ctrl;

    // Control registers.
    logic r_draining, n_draining;
    logic r_dropped,  n_dropped;
    logic r_out_valid, n_out_valid;
    isc_pkg::t_out_item r_out, n_out;

    logic accept_in;
    logic full;

    assign o_in_ready = !r_draining;
    assign accept_in  = i_in_valid && o_in_ready;

    // The list fills from cell 0 upward, so the top cell tells whether it is full.
    assign full = c_valid[D-1];

    // While draining, the chain moves down whenever the output register is free
    // or its result is taken in this cycle.
    assign ctrl.insert = accept_in && !full;
    assign ctrl.shift  = r_draining && (!r_out_valid || i_out_ready);

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            logic                               left_valid;
            logic                               left_gt;
            logic signed [isc_pkg::VALUE_W-1:0] left_value;
            logic                               right_valid;
            logic signed [isc_pkg::VALUE_W-1:0] right_value;

            // Cell 0 sees a boundary that always lets the new value in.
            if (g == 0) begin : g_left_edge
                assign left_valid = 1'b1;
                assign left_gt    = 1'b0;
                assign left_value = i_in_data.value;
            end else begin : g_left_link
                assign left_valid = c_valid[g-1];
                assign left_gt    = c_gt[g-1];
                assign left_value = c_value[g-1];
            end

            // The top cell empties itself when the chain moves down.
            if (g == D - 1) begin : g_right_edge
                assign right_valid = 1'b0;
                assign right_value = c_value[g];
            end else begin : g_right_link
                assign right_valid = c_valid[g+1];
                assign right_value = c_value[g+1];
            end

            isc_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (ctrl),
                .i_ins_value   (i_in_data.value),
                .i_left_valid  (left_valid),
                .i_left_gt     (left_gt),
                .i_left_value  (left_value),
                .i_right_valid (right_valid),
                .i_right_value (right_value),
                .o_valid       (c_valid[g]),
                .o_gt          (c_gt[g]),
                .o_value       (c_value[g])
            );
        end
    endgenerate

    always_comb begin
        n_draining  = r_draining;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // A value that finds the list full is lost, and the run is flagged.
        if (accept_in && full) begin
            n_dropped = 1'b1;
        end
        if (accept_in && i_in_data.last) begin
            n_draining = 1'b1;
        end

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // Cell 0 holds the smallest remaining entry; when cell 1 is empty it
        // is the last one of the run, and the run state returns to empty.
        if (ctrl.shift) begin
            n_out_valid        = 1'b1;
            n_out.sorted_value = c_value[0];
            n_out.run_end      = !c_valid[1];
            n_out.overflow     = r_dropped;
            if (!c_valid[1]) begin
                n_draining = 1'b0;
                n_dropped  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining  <= 1'b0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_draining  <= n_draining;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
